// ===== hdl/pfn_pkg.sv =====
`default_nettype none
package pfn_pkg;

  // Sum of three squared 30-bit magnitudes stays below 2^62
  localparam int SUM_W  = 62;
  localparam int ROOT_W = 31;

  // Output normal component, signed Q1.14 style word
  localparam int NORMAL_W = 16;
  localparam logic [NORMAL_W-1:0] NORMAL_MAX = 16'h7FFF;

  // Request into the square root unit
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] radicand;
  } sqrt_req_t;

endpackage
`default_nettype wire

// ===== hdl/polygon_face_normal.sv =====
`default_nettype none
// Face normal unit. Vertices stream in one per beat and are grouped into
// triangles or quads by primitive_mode. The closing vertex starts the
// normal: six products on one shared 31x31 multiplier, a magnitude step,
// a one-bit-per-cycle normalizing shift, three squares, a square root,
// and three restoring divides of NORMAL_FRAC_BITS+3 quotient bits each,
// before the first result beat. One result beat per corner follows;
// non-closing vertices of the next primitive are taken while those beats
// drain. A zero cross product skips the math and gives a zero normal with
// degenerate set.
module polygon_face_normal #(
  parameter int COORD_BITS       = 24,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic                                 primitive_mode,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [COORD_BITS-1:0]         vertex_x,
  input  wire logic signed [COORD_BITS-1:0]         vertex_y,
  input  wire logic signed [COORD_BITS-1:0]         vertex_z,
  input  wire logic                                 mesh_end,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [pfn_pkg::NORMAL_W-1:0]       normal_x,
  output logic signed [pfn_pkg::NORMAL_W-1:0]       normal_y,
  output logic signed [pfn_pkg::NORMAL_W-1:0]       normal_z,
  output logic [1:0]                                corner_index,
  output logic                                      degenerate,
  output logic                                      last_of_run
);

  localparam int DS  = (COORD_BITS > 28) ? COORD_BITS - 28 : 0;
  localparam int EW  = COORD_BITS + 1 - DS;
  localparam int CW  = 2 * EW;
  localparam int MW  = 31;
  localparam int MGW = (CW > 31) ? CW : 31;
  localparam int QW  = NORMAL_FRAC_BITS + 3;
  localparam int DW  = NORMAL_FRAC_BITS + 34;
  localparam int NW  = pfn_pkg::NORMAL_W;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_ABS, S_NORM, S_SQR, S_ROOT, S_DIV, S_EMIT
  } state_t;

  state_t state;
  logic   mode;
  logic [1:0] corner_count;
  logic [5:0] cnt;
  logic [1:0] comp;
  logic [1:0] emit_k;
  logic [1:0] emit_last;

  logic signed [COORD_BITS-1:0] sv [3][3];
  logic signed [COORD_BITS-1:0] cur [3];
  logic signed [EW-1:0]  e1 [3];
  logic signed [EW-1:0]  e2 [3];
  logic signed [CW-1:0]  c  [3];
  logic [MGW-1:0]        mg [3];
  logic signed [NW-1:0]  n  [3];
  logic                  degen;

  logic signed [MW-1:0]   op_a, op_b;
  logic signed [2*MW-1:0] prod;
  logic [pfn_pkg::SUM_W-1:0]  sum;
  logic [pfn_pkg::ROOT_W-1:0] root;
  logic [pfn_pkg::ROOT_W-1:0] sq_root;
  logic                       sq_done;
  pfn_pkg::sqrt_req_t         sq_req;
  logic [pfn_pkg::ROOT_W-1:0] rsel;

  logic [DW-1:0] num, dv;
  logic [QW-1:0] q, qf;
  logic [QW+NW-1:0] qwide;
  logic [NW-1:0] magv;
  logic          ge;

  logic [1:0] last_corner;
  logic       finishing;
  logic       in_acc, out_acc;
  logic [MGW-1:0] orv;
  logic       norm_hi, norm_lo;
  logic [1:0] next_comp;

  function automatic logic signed [EW-1:0] edge_f(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic signed [COORD_BITS:0] d;
    logic [COORD_BITS:0] mag;
    logic [COORD_BITS:0] sh;
    d   = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    mag = d[COORD_BITS] ? -d : d;
    sh  = mag >> DS;
    return d[COORD_BITS] ? $signed(-sh[EW-1:0]) : $signed(sh[EW-1:0]);
  endfunction

  function automatic logic [DW-1:0] num_f(input logic [MGW-1:0] m,
                                          input logic [pfn_pkg::ROOT_W-1:0] r);
    return (DW'(m[29:0]) << NORMAL_FRAC_BITS) + DW'(r >> 1);
  endfunction

  assign cur[0] = vertex_x;
  assign cur[1] = vertex_y;
  assign cur[2] = vertex_z;

  assign cfg_ready   = 1'b1;
  assign last_corner = mode ? 2'd3 : 2'd2;
  assign finishing   = corner_count >= last_corner;
  assign in_ready    = (state == S_IDLE) || (state == S_EMIT && !finishing);
  assign in_acc      = in_valid && in_ready;
  assign out_valid   = (state == S_EMIT);
  assign out_acc     = out_valid && out_ready;

  assign normal_x     = n[0];
  assign normal_y     = n[1];
  assign normal_z     = n[2];
  assign corner_index = emit_k;
  assign degenerate   = degen;
  assign last_of_run  = (emit_k == emit_last);

  // Normalizing shift tests on the OR of all magnitudes
  assign orv     = mg[0] | mg[1] | mg[2];
  assign norm_hi = |orv[MGW-1:30];
  assign norm_lo = ~|orv[MGW-1:29];

  // Shared multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    if (state == S_MUL) begin
      case (cnt[2:0])
        3'd0: begin op_a = MW'(e1[1]); op_b = MW'(e2[2]); end
        3'd1: begin op_a = MW'(e1[2]); op_b = MW'(e2[1]); end
        3'd2: begin op_a = MW'(e1[2]); op_b = MW'(e2[0]); end
        3'd3: begin op_a = MW'(e1[0]); op_b = MW'(e2[2]); end
        3'd4: begin op_a = MW'(e1[0]); op_b = MW'(e2[1]); end
        3'd5: begin op_a = MW'(e1[1]); op_b = MW'(e2[0]); end
        default: begin op_a = '0; op_b = '0; end
      endcase
    end else if (state == S_SQR && cnt < 6'd3) begin
      op_a = $signed({1'b0, mg[cnt[1:0]][29:0]});
      op_b = $signed({1'b0, mg[cnt[1:0]][29:0]});
    end
  end

  // Square root request: last square folds in on the way
  assign sq_req.start    = (state == S_SQR) && (cnt == 6'd3);
  assign sq_req.radicand = sum + prod[pfn_pkg::SUM_W-1:0];

  pfn_isqrt u_isqrt (
    .clk  (clk),
    .rst  (rst),
    .req  (sq_req),
    .done (sq_done),
    .root (sq_root)
  );

  // Divide step and final rounding clamp
  assign rsel      = (state == S_ROOT) ? sq_root : root;
  assign ge        = num >= dv;
  assign qf        = {q[QW-2:0], ge};
  assign qwide     = (QW+NW)'(qf);
  assign magv      = (qwide > (QW+NW)'(pfn_pkg::NORMAL_MAX)) ?
                     pfn_pkg::NORMAL_MAX : qwide[NW-1:0];
  assign next_comp = comp + 2'd1;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      mode         <= 1'b0;
      corner_count <= 2'd0;
      cnt          <= '0;
      comp         <= 2'd0;
      emit_k       <= 2'd0;
      emit_last    <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode <= primitive_mode;
      end
      // Count corners; drop a partial primitive at mesh end
      if (in_acc) begin
        if (finishing) begin
          corner_count <= 2'd0;
          emit_last    <= last_corner;
        end else if (mesh_end) begin
          corner_count <= 2'd0;
        end else begin
          corner_count <= corner_count + 2'd1;
        end
      end
      case (state)
        S_IDLE: begin
          if (in_acc && finishing) begin
            state <= S_MUL;
            cnt   <= '0;
          end
        end
        S_MUL: begin
          if (cnt == 6'd6) begin
            state <= S_ABS;
          end
          cnt <= cnt + 6'd1;
        end
        S_ABS: begin
          emit_k <= 2'd0;
          if (c[0] == '0 && c[1] == '0 && c[2] == '0) begin
            state <= S_EMIT;
          end else begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (!norm_hi && !norm_lo) begin
            state <= S_SQR;
            cnt   <= '0;
          end
        end
        S_SQR: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'd3) begin
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (sq_done) begin
            state <= S_DIV;
            comp  <= 2'd0;
            cnt   <= '0;
          end
        end
        S_DIV: begin
          if (cnt == 6'(QW - 1)) begin
            cnt <= '0;
            if (comp == 2'd2) begin
              state <= S_EMIT;
            end else begin
              comp <= next_comp;
            end
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_EMIT: begin
          if (out_acc) begin
            if (emit_k == emit_last) begin
              state <= S_IDLE;
            end else begin
              emit_k <= emit_k + 2'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    if (in_acc && !finishing && !mesh_end) begin
      for (int i = 0; i < 3; i++) begin
        sv[corner_count][i] <= cur[i];
      end
    end
    if (in_acc && finishing) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= edge_f(sv[1][i], sv[0][i]);
        e2[i] <= edge_f(cur[i], sv[0][i]);
      end
    end
    case (state)
      S_MUL: begin
        // Accumulate the previous cycle's product
        case (cnt[2:0])
          3'd1: c[0] <= prod[CW-1:0];
          3'd2: c[0] <= c[0] - prod[CW-1:0];
          3'd3: c[1] <= prod[CW-1:0];
          3'd4: c[1] <= c[1] - prod[CW-1:0];
          3'd5: c[2] <= prod[CW-1:0];
          3'd6: c[2] <= c[2] - prod[CW-1:0];
          default: ;
        endcase
      end
      S_ABS: begin
        degen <= (c[0] == '0 && c[1] == '0 && c[2] == '0);
        for (int i = 0; i < 3; i++) begin
          mg[i] <= MGW'(c[i][CW-1] ? -c[i] : c[i]);
          n[i]  <= '0;
        end
      end
      S_NORM: begin
        for (int i = 0; i < 3; i++) begin
          if (norm_hi) begin
            mg[i] <= mg[i] >> 1;
          end else if (norm_lo) begin
            mg[i] <= mg[i] << 1;
          end
        end
      end
      S_SQR: begin
        if (cnt == 6'd1) begin
          sum <= prod[pfn_pkg::SUM_W-1:0];
        end else if (cnt == 6'd2) begin
          sum <= sum + prod[pfn_pkg::SUM_W-1:0];
        end
      end
      S_ROOT: begin
        if (sq_done) begin
          root <= sq_root;
          num  <= num_f(mg[0], rsel);
          dv   <= DW'(rsel) << (QW - 1);
          q    <= '0;
        end
      end
      S_DIV: begin
        if (cnt == 6'(QW - 1)) begin
          n[comp] <= c[comp][CW-1] ? -magv : magv;
          if (comp != 2'd2) begin
            num <= num_f(mg[next_comp], rsel);
            dv  <= DW'(rsel) << (QW - 1);
            q   <= '0;
          end
        end else begin
          num <= ge ? num - dv : num;
          dv  <= dv >> 1;
          q   <= qf;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/pfn_isqrt.sv =====
`default_nettype none
module pfn_isqrt (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire pfn_pkg::sqrt_req_t        req,
  output logic                           done,
  output logic [pfn_pkg::ROOT_W-1:0]     root
);

  logic                      busy;
  logic [pfn_pkg::SUM_W-1:0] s;
  logic [pfn_pkg::SUM_W-1:0] res;
  logic [pfn_pkg::SUM_W-1:0] bitr;
  logic [pfn_pkg::SUM_W-1:0] trial;

  // Trial subtrahend for this digit
  assign trial = res + bitr;
  assign root  = res[pfn_pkg::ROOT_W-1:0];

  // Control: one result digit per cycle, done pulses once
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && bitr[0]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: restoring square root, two radicand bits per step
  always_ff @(posedge clk) begin
    if (req.start) begin
      s    <= req.radicand;
      res  <= '0;
      bitr <= pfn_pkg::SUM_W'(1) << (pfn_pkg::SUM_W - 2);
    end else if (busy) begin
      if (s >= trial) begin
        s   <= s - trial;
        res <= (res >> 1) + bitr;
      end else begin
        res <= res >> 1;
      end
      bitr <= bitr >> 2;
    end
  end

endmodule
`default_nettype wire

// ===== bench/normal_checker.sv =====
`default_nettype none
module normal_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic               primitive_mode,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic signed [23:0] vertex_x,
  input  wire logic signed [23:0] vertex_y,
  input  wire logic signed [23:0] vertex_z,
  input  wire logic               mesh_end,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic signed [15:0] normal_x,
  input  wire logic signed [15:0] normal_y,
  input  wire logic signed [15:0] normal_z,
  input  wire logic [1:0]         corner_index,
  input  wire logic               degenerate,
  input  wire logic               last_of_run,
  output int                      fail_count,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 14;

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [1:0]         corner;
    logic               degen;
    logic               last;
  } normal_beat_t;

  normal_beat_t normal_queue[$];
  logic         quad_mode;
  logic [1:0]   corners_held;
  longint       held_vtx[3][3];

  assign pending = normal_queue.size();

  // Integer square root, bit by bit
  function automatic longint unsigned root64(input longint unsigned s);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Close a primitive: cross product, normalize, queue one beat per corner
  task automatic close_primitive(input longint vx, input longint vy, input longint vz,
                                 input int last_corner);
    longint e1[3], e2[3], c[3];
    longint unsigned m[3], mx, s, r, q;
    logic signed [15:0] n[3];
    normal_beat_t b;
    int sh;
    e1[0] = held_vtx[1][0] - held_vtx[0][0];
    e1[1] = held_vtx[1][1] - held_vtx[0][1];
    e1[2] = held_vtx[1][2] - held_vtx[0][2];
    e2[0] = vx - held_vtx[0][0];
    e2[1] = vy - held_vtx[0][1];
    e2[2] = vz - held_vtx[0][2];
    c[0] = e1[1] * e2[2] - e1[2] * e2[1];
    c[1] = e1[2] * e2[0] - e1[0] * e2[2];
    c[2] = e1[0] * e2[1] - e1[1] * e2[0];
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = c[i] < 0 ? longint'(-c[i]) : longint'(c[i]);
      if (m[i] > mx) mx = m[i];
    end
    b.degen = (mx == 0);
    if (mx == 0) begin
      n[0] = 0; n[1] = 0; n[2] = 0;
    end else begin
      sh = 0;
      while ((mx >> sh) >= (64'd1 << 30)) sh++;
      for (int i = 0; i < 3; i++) m[i] >>= sh;
      mx >>= sh;
      sh = 0;
      while ((mx << sh) < (64'd1 << 29)) sh++;
      s = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] <<= sh;
        s += m[i] * m[i];
      end
      r = root64(s);
      for (int i = 0; i < 3; i++) begin
        q = ((m[i] << FRAC) + (r >> 1)) / r;
        if (q > 32767) q = 32767;
        n[i] = c[i] < 0 ? -16'(q) : 16'(q);
      end
    end
    for (int k = 0; k <= last_corner; k++) begin
      b.nx = n[0]; b.ny = n[1]; b.nz = n[2];
      b.corner = 2'(k);
      b.last = (k == last_corner);
      normal_queue.push_back(b);
    end
  endtask

  // Track config, vertices and result beats at each rising edge
  always @(posedge clk) begin
    normal_beat_t want;
    int last_corner;
    int errs;
    if (rst) begin
      quad_mode <= 1'b0;
      corners_held = 0;
      fail_count <= 0;
      normal_queue.delete();
    end else begin
      errs = 0;
      if (cfg_valid && cfg_ready) quad_mode <= primitive_mode;
      if (in_valid && in_ready) begin
        last_corner = quad_mode ? 3 : 2;
        if (corners_held < last_corner) begin
          if (mesh_end) begin
            corners_held = 0;
          end else begin
            held_vtx[corners_held][0] = vertex_x;
            held_vtx[corners_held][1] = vertex_y;
            held_vtx[corners_held][2] = vertex_z;
            corners_held = corners_held + 1;
          end
        end else begin
          close_primitive(vertex_x, vertex_y, vertex_z, last_corner);
          corners_held = 0;
        end
      end
      if (out_valid && out_ready) begin
        if (normal_queue.size() == 0) begin
          $error("unexpected normal beat");
          errs++;
        end else begin
          want = normal_queue.pop_front();
          if (normal_x !== want.nx) begin
            $error("normal_x expected %0d actual %0d", want.nx, normal_x);
            errs++;
          end
          if (normal_y !== want.ny) begin
            $error("normal_y expected %0d actual %0d", want.ny, normal_y);
            errs++;
          end
          if (normal_z !== want.nz) begin
            $error("normal_z expected %0d actual %0d", want.nz, normal_z);
            errs++;
          end
          if (corner_index !== want.corner) begin
            $error("corner_index expected %0d actual %0d", want.corner, corner_index);
            errs++;
          end
          if (degenerate !== want.degen) begin
            $error("degenerate expected %0d actual %0d", want.degen, degenerate);
            errs++;
          end
          if (last_of_run !== want.last) begin
            $error("last_of_run expected %0d actual %0d", want.last, last_of_run);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic primitive_mode = 1'b0;
  logic in_valid = 1'b0;
  logic signed [23:0] vertex_x = '0;
  logic signed [23:0] vertex_y = '0;
  logic signed [23:0] vertex_z = '0;
  logic mesh_end = 1'b0;
  logic out_ready = 1'b0;
  logic cfg_ready, in_ready, out_valid;
  logic signed [15:0] normal_x, normal_y, normal_z;
  logic [1:0] corner_index;
  logic degenerate, last_of_run;
  int fail_count, pending;
  int idle_cycles = 0;
  bit hold_out = 1'b0;

  always #5 clk = ~clk;

  polygon_face_normal DUT (
    .clk, .rst, .cfg_valid, .cfg_ready, .primitive_mode,
    .in_valid, .in_ready, .vertex_x, .vertex_y, .vertex_z, .mesh_end,
    .out_valid, .out_ready, .normal_x, .normal_y, .normal_z,
    .corner_index, .degenerate, .last_of_run
  );

  normal_checker checker_i (.*);

  // Count cycles with no beat on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("polygon_face_normal verification failed");
      $finish;
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drive ready with random stalls, or hold it low on request
  initial begin
    int g;
    @(negedge clk);
    forever begin
      if (hold_out) begin
        out_ready <= 1'b0;
        @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
        g = gap_len();
        if (g > 0) begin
          out_ready <= 1'b0;
          repeat (g) @(negedge clk);
        end
      end
    end
  end

  task automatic send_vertex(input logic [23:0] x, input logic [23:0] y,
                             input logic [23:0] z, input logic me);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    vertex_x <= x;
    vertex_y <= y;
    vertex_z <= z;
    mesh_end <= me;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [23:0] rnd_coord();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 24'h7FFFFF;
    if (p == 1) return 24'h800000;
    if (p < 5) return 24'($signed($urandom_range(0, 4000)) - 2000);
    return 24'($urandom);
  endfunction

  // Wait for all normals, let the tail settle, then write the mode
  task automatic set_mode(input logic m);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    cfg_valid <= 1'b1;
    primitive_mode <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [23:0] r;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    // Triangles at the coordinate extremes
    send_vertex(24'h800000, 24'h800000, 24'h800000, 0);
    send_vertex(24'h7FFFFF, 24'h800000, 24'h800000, 0);
    send_vertex(24'h800000, 24'h7FFFFF, 24'h800000, 0);
    send_vertex(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 0);
    send_vertex(24'h000000, 24'h800000, 24'h7FFFFF, 0);
    send_vertex(24'h800000, 24'h000000, 24'h7FFFFF, 1);
    // Zero cross product: repeated point
    send_vertex(24'd5, 24'd5, 24'd5, 0);
    send_vertex(24'd5, 24'd5, 24'd5, 0);
    send_vertex(24'd9, 24'd1, 24'd3, 0);
    // Collinear points
    send_vertex(24'd0, 24'd0, 24'd0, 0);
    send_vertex(24'd1, 24'd1, 24'd1, 0);
    send_vertex(24'd2, 24'd2, 24'd2, 0);
    // Partial primitive at mesh end
    send_vertex(24'd100, 24'd3, 24'd7, 0);
    send_vertex(24'd1, 24'd300, 24'd7, 1);
    // Small unit triangle
    send_vertex(24'd0, 24'd0, 24'd0, 0);
    send_vertex(24'd1, 24'd0, 24'd0, 0);
    send_vertex(24'd0, 24'd1, 24'd0, 0);
    set_mode(1'b1);
    // Quad, and a partial quad at mesh end
    send_vertex(24'd0, 24'd0, 24'd0, 0);
    send_vertex(24'd4096, 24'd0, 24'd0, 0);
    send_vertex(24'd4096, 24'd4096, 24'd0, 0);
    send_vertex(24'd0, 24'd4096, 24'd4096, 1);
    send_vertex(24'd1, 24'd2, 24'd3, 0);
    send_vertex(24'd4, 24'd5, 24'd6, 0);
    send_vertex(24'd7, 24'd8, 24'd9, 1);
    // Random phases; receiver holds off in one of them
    for (int ph = 0; ph < 6; ph++) begin
      set_mode(ph[0]);
      if (ph == 2) begin
        fork
          begin
            hold_out = 1'b1;
            repeat (400) @(negedge clk);
            hold_out = 1'b0;
          end
        join_none
      end
      for (int i = 0; i < 85; i++) begin
        r = rnd_coord();
        send_vertex(rnd_coord(), rnd_coord(), ($urandom_range(0, 15) == 0) ? r : rnd_coord(),
                    $urandom_range(0, 19) == 0);
      end
    end
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (fail_count == 0)
      $display("polygon_face_normal verification clean");
    else
      $display("polygon_face_normal verification failed");
    $finish;
  end
endmodule
`default_nettype wire
